/* rtl/core/length_prefixed_frame_receiver_assert.svh */
// Assertion macros for the frame receiver. Each use needs clk and arst_n in scope.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define LPFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpfr: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define LPFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpfr: next-cycle check failed");
`else
`define LPFR_ASSERT_NOW(lbl, ante, cons)
`define LPFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/lpfr_pkg.sv */
package lpfr_pkg;

	localparam int BUFFER_BYTES_DEF = 64;

	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 6;
	localparam int LEN_OUT_W = 7;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	// input operations
	localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// parser phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_END  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADLEN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADEND = 3'd4;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
	localparam logic [BYTE_W-1:0] START_RESET = 8'd2;
	localparam logic [BYTE_W-1:0] END_RESET   = 8'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] rx_byte;
		logic [IDX_W-1:0]  read_index;
	} beat_t;

	typedef struct packed {
		logic                 read_hit;
		logic                 frame_ready;
		logic [LEN_OUT_W-1:0] ready_length;
		logic [STATUS_W-1:0]  status;
	} res_t;

endpackage

/* rtl/core/length_prefixed_frame_receiver.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_ready    | op, rx_byte, read_index
// result   | out_valid / out_ready  | read_data, frame_ready, ready_length, status
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// One beat per cycle sustained while results are taken; a result passes through the
// input register, then the result register and payload RAM read port, before it
// shows on the outputs.
// Parser state advances as the beat leaves the input register, so each beat sees
// the state left by the one before it without any bubble.
// arst_n clears parser state and both pipeline valids and resets the marker registers.
// Payload RAM is not cleared; only bytes written for a held frame are readable.
// A stalled result holds the result register and RAM read data; the input
// register keeps accepting until it is also full.

`include "length_prefixed_frame_receiver_assert.svh"

module length_prefixed_frame_receiver #(
	parameter int BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpfr_pkg::OP_W-1:0]         op,
	input  logic [lpfr_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [lpfr_pkg::IDX_W-1:0]        read_index,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lpfr_pkg::BYTE_W-1:0]       read_data,
	output logic                              frame_ready,
	output logic [lpfr_pkg::LEN_OUT_W-1:0]    ready_length,
	output logic [lpfr_pkg::STATUS_W-1:0]     status,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpfr_pkg::BYTE_W-1:0]       cfg_data
);

	import lpfr_pkg::*;

	localparam int DEPTH  = 2 * BUFFER_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	// marker registers
	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;

	// input register
	logic  valid_s1;
	beat_t beat_s1;
	logic  fire_s1;

	// result register
	logic  valid_s2;
	res_t  res_s2;
	res_t  res_c;

	// payload RAM
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// Config writes take effect at the next clock edge; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_RESET;
			end_marker_q   <= END_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START: start_marker_q <= cfg_data;
				CFG_END:   end_marker_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input beat whenever the result slot is empty or being drained.
	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1.op         <= op;
			beat_s1.rx_byte    <= rx_byte;
			beat_s1.read_index <= read_index;
		end
	end

	lpfr_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat_s1),
		.fire        (fire_s1),
		.start_marker(start_marker_q),
		.end_marker  (end_marker_q),
		.res         (res_c),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	// Read data is registered inside the RAM and held while the result stalls,
	// since the read enable only fires together with fire_s1.
	lpfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid    = valid_s2;
	// Drop the RAM word unless this beat was a read that hit the held frame.
	assign read_data    = res_s2.read_hit ? mem_rdata : '0;
	assign frame_ready  = res_s2.frame_ready;
	assign ready_length = res_s2.ready_length;
	assign status       = res_s2.status;

	`LPFR_ASSERT_NOW(a_accept_sets_ready, out_valid && status == ST_ACCEPT, frame_ready)
	`LPFR_ASSERT_NOW(a_data_needs_frame, out_valid && read_data != '0, frame_ready)
	`LPFR_ASSERT_NOW(a_length_needs_frame, out_valid && ready_length != '0, frame_ready)
	`LPFR_ASSERT_NOW(a_stall_only_on_back, !in_ready, out_valid && !out_ready && valid_s1)
	`LPFR_ASSERT_NEXT(a_stall_holds_data, out_valid && !out_ready, read_data == $past(read_data))

endmodule

/* rtl/core/lpfr_ram.sv */
module lpfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/lpfr_parser.sv */
module lpfr_parser #(
	parameter int BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lpfr_pkg::beat_t                        beat,
	input  logic                                   fire,
	input  logic [lpfr_pkg::BYTE_W-1:0]            start_marker,
	input  logic [lpfr_pkg::BYTE_W-1:0]            end_marker,
	output lpfr_pkg::res_t                         res,
	output logic                                   mem_we,
	output logic [$clog2(2*BUFFER_BYTES)-1:0]      mem_waddr,
	output logic [lpfr_pkg::BYTE_W-1:0]            mem_wdata,
	output logic                                   mem_re,
	output logic [$clog2(2*BUFFER_BYTES)-1:0]      mem_raddr
);

	import lpfr_pkg::*;

	localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = $clog2(2 * BUFFER_BYTES);
	localparam int CMP_W  = BYTE_W + 1;
	localparam logic [CMP_W-1:0]  LEN_LIMIT = CMP_W'(BUFFER_BYTES);
	localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(BUFFER_BYTES);

	logic [1:0]       phase_q, phase_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [LEN_W-1:0] exp_q, exp_d;
	logic             sel_q, sel_d;
	logic             rdy_q, rdy_d;
	logic [LEN_W-1:0] held_q, held_d;

	logic [STATUS_W-1:0] status_c;
	logic                we_c;
	logic                re_c;
	logic [LEN_W-1:0]    cnt_inc;
	logic                len_too_big;
	logic                read_hit;

	assign cnt_inc     = cnt_q + LEN_W'(1);
	assign len_too_big = {1'b0, beat.rx_byte} > LEN_LIMIT;
	assign read_hit    = rdy_q && (CMP_W'(beat.read_index) < CMP_W'(held_q));

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		exp_d    = exp_q;
		sel_d    = sel_q;
		rdy_d    = rdy_q;
		held_d   = held_q;
		status_c = ST_NONE;
		we_c     = 1'b0;
		re_c     = 1'b0;
		unique case (beat.op)
			OP_BYTE: begin
				unique case (phase_q)
					PH_HUNT: begin
						if (beat.rx_byte == start_marker) begin
							phase_d = PH_LEN;
						end
					end
					PH_LEN: begin
						if (len_too_big) begin
							phase_d  = PH_HUNT;
							status_c = ST_BADLEN;
						end else begin
							exp_d   = LEN_W'(beat.rx_byte);
							cnt_d   = '0;
							// empty payload: next byte is the end marker
							phase_d = (beat.rx_byte == '0) ? PH_END : PH_DATA;
						end
					end
					PH_DATA: begin
						we_c  = 1'b1;
						cnt_d = cnt_inc;
						if (cnt_inc >= exp_q) begin
							phase_d = PH_END;
						end
					end
					PH_END: begin
						priority if (beat.rx_byte != end_marker) begin
							status_c = ST_BADEND;
						end else if (rdy_q) begin
							status_c = ST_BUSY;
						end else begin
							rdy_d    = 1'b1;
							held_d   = exp_q;
							sel_d    = ~sel_q;
							status_c = ST_ACCEPT;
						end
						phase_d = PH_HUNT;
					end
				endcase
			end
			OP_READ: begin
				re_c = read_hit;
			end
			OP_RELEASE: begin
				rdy_d  = 1'b0;
				held_d = '0;
			end
			default: begin
			end
		endcase
	end

	// fill half selected by sel_q, ready half is the other one
	assign mem_we    = fire && we_c;
	assign mem_waddr = (sel_q ? HALF_BASE : '0) + ADDR_W'(cnt_q);
	assign mem_wdata = beat.rx_byte;
	assign mem_re    = fire && re_c;
	assign mem_raddr = (sel_q ? '0 : HALF_BASE) + ADDR_W'(beat.read_index);

	assign res.read_hit     = re_c;
	assign res.frame_ready  = rdy_d;
	assign res.ready_length = rdy_d ? LEN_OUT_W'(held_d) : '0;
	assign res.status       = status_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			exp_q   <= '0;
			sel_q   <= 1'b0;
			rdy_q   <= 1'b0;
			held_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			exp_q   <= exp_d;
			sel_q   <= sel_d;
			rdy_q   <= rdy_d;
			held_q  <= held_d;
		end
	end

endmodule
